// ----- design/assert_macros.svh -----
// assertion macros used by the ready queue datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/pfrq_pkg.sv -----
// shared types and constants of the priority ready queue
package pfrq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT   = 16;
   localparam int PRIORITY_BITS_DEFAULT = 8;

   localparam int THREAD_W = 4;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_REMOVE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DUP    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd3;

   typedef struct packed {
      logic load;
      logic compare;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic rsp_valid;
   } dp_status_type;

endpackage

// ----- design/pfrq_ctrl.sv -----
// sequencer of the priority ready queue: accept, compare, write back
module pfrq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   input  pfrq_pkg::dp_status_type dp_status,
   output pfrq_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_COMPARE = 2'd1;
   localparam logic [1:0] S_WRITE   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       out_free;

   // result register is free when empty or being taken this cycle
   assign out_free  = !dp_status.rsp_valid || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               cmd.write = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/pfrq_datapath.sv -----
// slot array with parallel compare and shift, plus the result register
`include "assert_macros.svh"

module pfrq_datapath #(
   parameter int QUEUE_DEPTH   = pfrq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = pfrq_pkg::PRIORITY_BITS_DEFAULT,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pfrq_pkg::cmd_type              cmd,
   output pfrq_pkg::dp_status_type        dp_status,
   input  logic                           req_op,
   input  logic [pfrq_pkg::THREAD_W-1:0]  req_thread_id,
   input  logic [pfrq_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic                           rsp_head_valid,
   output logic [pfrq_pkg::THREAD_W-1:0]  rsp_head_thread,
   output logic [pfrq_pkg::PRIO_W-1:0]    rsp_head_priority,
   output logic [CNT_W-1:0]               rsp_entry_count,
   output logic [pfrq_pkg::STATUS_W-1:0]  rsp_status
);

   logic                          op_ff;
   logic [pfrq_pkg::THREAD_W-1:0] tid_ff;
   logic [PRIORITY_BITS-1:0]      prio_ff;

   logic [pfrq_pkg::THREAD_W-1:0] slot_thread_ff [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0]      slot_prio_ff   [QUEUE_DEPTH];
   logic [pfrq_pkg::THREAD_W-1:0] slot_thread_in [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0]      slot_prio_in   [QUEUE_DEPTH];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic [QUEUE_DEPTH-1:0] match_c;
   logic [QUEUE_DEPTH-1:0] at_pos_c;
   logic [QUEUE_DEPTH-1:0] after_c;
   logic [QUEUE_DEPTH-1:0] match_ff;
   logic [QUEUE_DEPTH-1:0] at_pos_ff;
   logic [QUEUE_DEPTH-1:0] after_ff;

   logic                          any_match;
   logic                          is_full;
   logic                          enq_ok;
   logic                          rem_ok;
   logic [pfrq_pkg::STATUS_W-1:0] status_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          head_valid_ff;
   logic [pfrq_pkg::THREAD_W-1:0] head_thread_ff;
   logic [pfrq_pkg::PRIO_W-1:0]   head_prio_ff;
   logic [CNT_W-1:0]              count_out_ff;
   logic [pfrq_pkg::STATUS_W-1:0] status_ff;

   // per-slot compare: thread match, insert point, and slots at or after a match
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
      logic slot_used;
      assign slot_used   = (count_ff > CNT_W'(i));
      assign match_c[i]  = slot_used && (slot_thread_ff[i] == tid_ff);
      assign at_pos_c[i] = !slot_used || (slot_prio_ff[i] > prio_ff);
      assign after_c[i]  = |match_c[i:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         tid_ff  <= req_thread_id;
         prio_ff <= PRIORITY_BITS'(req_priority_req);
      end
      if (cmd.compare) begin
         match_ff  <= match_c;
         at_pos_ff <= at_pos_c;
         after_ff  <= after_c;
      end
   end

   assign any_match = |match_ff;
   assign is_full   = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign enq_ok    = (op_ff == pfrq_pkg::OP_ENQUEUE) && !any_match && !is_full;
   assign rem_ok    = (op_ff == pfrq_pkg::OP_REMOVE) && any_match;

   always_comb begin
      priority if (op_ff == pfrq_pkg::OP_REMOVE) begin
         status_in = any_match ? pfrq_pkg::STAT_DONE : pfrq_pkg::STAT_ABSENT;
      end else if (any_match) begin
         status_in = pfrq_pkg::STAT_DUP;
      end else if (is_full) begin
         status_in = pfrq_pkg::STAT_FULL;
      end else begin
         status_in = pfrq_pkg::STAT_DONE;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // shift network: insert opens a gap at the first greater slot, remove closes one
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_shift
      logic                          from_prev;
      logic [pfrq_pkg::THREAD_W-1:0] next_thread;
      logic [PRIORITY_BITS-1:0]      next_prio;
      if (i == 0) begin : g_first
         assign from_prev = 1'b0;
      end else begin : g_rest
         assign from_prev = at_pos_ff[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_thread = slot_thread_ff[i];
         assign next_prio   = slot_prio_ff[i];
      end else begin : g_mid
         assign next_thread = slot_thread_ff[i+1];
         assign next_prio   = slot_prio_ff[i+1];
      end
      always_comb begin
         slot_thread_in[i] = slot_thread_ff[i];
         slot_prio_in[i]   = slot_prio_ff[i];
         if (enq_ok && at_pos_ff[i]) begin
            if (from_prev) begin
               slot_thread_in[i] = slot_thread_ff[(i == 0) ? 0 : i-1];
               slot_prio_in[i]   = slot_prio_ff[(i == 0) ? 0 : i-1];
            end else begin
               slot_thread_in[i] = tid_ff;
               slot_prio_in[i]   = prio_ff;
            end
         end else if (rem_ok && after_ff[i]) begin
            slot_thread_in[i] = next_thread;
            slot_prio_in[i]   = next_prio;
         end
      end
      always_ff @(posedge clock) begin
         if (cmd.write) begin
            slot_thread_ff[i] <= slot_thread_in[i];
            slot_prio_ff[i]   <= slot_prio_in[i];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.write) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         head_valid_ff <= (count_in != '0);
         count_out_ff  <= count_in;
         status_ff     <= status_in;
         if (count_in != '0) begin
            head_thread_ff <= slot_thread_in[0];
            head_prio_ff   <= pfrq_pkg::PRIO_W'(slot_prio_in[0]);
         end else begin
            head_thread_ff <= '0;
            head_prio_ff   <= '0;
         end
      end
   end

   assign dp_status.rsp_valid = rsp_valid_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_head_valid      = head_valid_ff;
   assign rsp_head_thread     = head_thread_ff;
   assign rsp_head_priority   = head_prio_ff;
   assign rsp_entry_count     = count_out_ff;
   assign rsp_status          = status_ff;

   `ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_HOLDS(a_single_match, clock, reset, cmd.write, $onehot0(match_ff))
   `ASSERT_NEXT(a_enq_grows, clock, reset, enq_ok && cmd.write, count_ff == $past(count_ff) + CNT_W'(1))
   `ASSERT_NEXT(a_rem_shrinks, clock, reset, rem_ok && cmd.write, count_ff == $past(count_ff) - CNT_W'(1))

endmodule

// ----- design/priority_fifo_ready_queue.sv -----
// top level of the priority ready queue: sequencer plus slot datapath
// steps: accept (request registered), compare (match results registered), write back
//   (response registered); no new request is taken until write back, which waits
//   while the response register is held by rsp_stall
// reset: synchronous, active high; empties the queue and drops any pending response
module priority_fifo_ready_queue #(
   parameter int QUEUE_DEPTH   = pfrq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = pfrq_pkg::PRIORITY_BITS_DEFAULT,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [pfrq_pkg::THREAD_W-1:0]  req_thread_id,
   input  logic [pfrq_pkg::PRIO_W-1:0]    req_priority_req,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_head_valid,
   output logic [pfrq_pkg::THREAD_W-1:0]  rsp_head_thread,
   output logic [pfrq_pkg::PRIO_W-1:0]    rsp_head_priority,
   output logic [CNT_W-1:0]               rsp_entry_count,
   output logic [pfrq_pkg::STATUS_W-1:0]  rsp_status
);

   // commands from the sequencer, status back from the datapath
   pfrq_pkg::cmd_type       cmd;
   pfrq_pkg::dp_status_type dp_status;

   // sequencer: takes a request only when idle, waits on a full response register
   pfrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // datapath: all slots compare in parallel, then shift one place in a single write
   pfrq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .req_op            (req_op),
      .req_thread_id     (req_thread_id),
      .req_priority_req  (req_priority_req),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_thread   (rsp_head_thread),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

endmodule

// ----- tb/priority_fifo_ready_queue_tb.sv -----
// testbench for the priority ready queue: scoreboard class plus request and response drivers
`timescale 1ns / 100ps

module priority_fifo_ready_queue_tb;

   localparam int DEPTH     = pfrq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int PRIO_USED = pfrq_pkg::PRIORITY_BITS_DEFAULT;
   localparam int COUNT_W   = $clog2(pfrq_pkg::QUEUE_DEPTH_DEFAULT + 1);
   localparam int THREAD_W  = pfrq_pkg::THREAD_W;
   localparam int PRIO_W    = pfrq_pkg::PRIO_W;
   localparam int STATUS_W  = pfrq_pkg::STATUS_W;

   // what the block reports after each request
   typedef struct {
      logic                head_valid;
      logic [THREAD_W-1:0] head_thread;
      logic [PRIO_W-1:0]   head_priority;
      logic [COUNT_W-1:0]  entry_count;
      logic [STATUS_W-1:0] status;
   } head_report_type;

   // shadow copy of the ready queue; predicts one report per accepted request
   class ready_queue_scoreboard;
      logic [THREAD_W-1:0] slot_tid[DEPTH];
      logic [PRIO_W-1:0]   slot_pri[DEPTH];
      int                  used;
      int                  errors;
      head_report_type     due_reports[$];

      function new();
         used   = 0;
         errors = 0;
      endfunction

      // slot that holds the thread, or used when it is not queued
      function int find_slot(logic [THREAD_W-1:0] tid);
         for (int i = 0; i < used; i++)
            if (slot_tid[i] == tid) return i;
         return used;
      endfunction

      function void note_request(logic op, logic [THREAD_W-1:0] tid, logic [PRIO_W-1:0] prio);
         head_report_type     want;
         int                  pos;
         int                  ins;
         logic [PRIO_W-1:0]   pri;
         pri = prio & PRIO_W'((1 << PRIO_USED) - 1);
         pos = find_slot(tid);
         if (op == pfrq_pkg::OP_ENQUEUE) begin
            // duplicate check wins over the full check
            if (pos < used)
               want.status = pfrq_pkg::STAT_DUP;
            else if (used >= DEPTH)
               want.status = pfrq_pkg::STAT_FULL;
            else begin
               // behind every entry of equal or more urgent priority
               ins = 0;
               while (ins < used && slot_pri[ins] <= pri) ins++;
               for (int i = used; i > ins; i--) begin
                  slot_tid[i] = slot_tid[i-1];
                  slot_pri[i] = slot_pri[i-1];
               end
               slot_tid[ins] = tid;
               slot_pri[ins] = pri;
               used++;
               want.status = pfrq_pkg::STAT_DONE;
            end
         end else begin
            if (pos >= used)
               want.status = pfrq_pkg::STAT_ABSENT;
            else begin
               for (int i = pos; i + 1 < used; i++) begin
                  slot_tid[i] = slot_tid[i+1];
                  slot_pri[i] = slot_pri[i+1];
               end
               used--;
               want.status = pfrq_pkg::STAT_DONE;
            end
         end
         want.head_valid    = (used > 0);
         want.head_thread   = (used > 0) ? slot_tid[0] : '0;
         want.head_priority = (used > 0) ? slot_pri[0] : '0;
         want.entry_count   = COUNT_W'(used);
         due_reports.push_back(want);
      endfunction

      function void flag_mismatch(string field, logic [15:0] want, logic [15:0] seen);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
         errors++;
      endfunction

      function void check_response(head_report_type seen);
         head_report_type want;
         if (due_reports.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none, actual status %0h",
                     $time, seen.status);
            errors++;
            return;
         end
         want = due_reports.pop_front();
         if (seen.head_valid !== want.head_valid)
            flag_mismatch("head_valid", 16'(want.head_valid), 16'(seen.head_valid));
         if (seen.head_thread !== want.head_thread)
            flag_mismatch("head_thread", 16'(want.head_thread), 16'(seen.head_thread));
         if (seen.head_priority !== want.head_priority)
            flag_mismatch("head_priority", 16'(want.head_priority), 16'(seen.head_priority));
         if (seen.entry_count !== want.entry_count)
            flag_mismatch("entry_count", 16'(want.entry_count), 16'(seen.entry_count));
         if (seen.status !== want.status)
            flag_mismatch("status", 16'(want.status), 16'(seen.status));
      endfunction
   endclass

   // every input known from time zero
   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_op           = pfrq_pkg::OP_ENQUEUE;
   logic [THREAD_W-1:0] req_thread_id    = '0;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic                rsp_head_valid;
   logic [THREAD_W-1:0] rsp_head_thread;
   logic [PRIO_W-1:0]   rsp_head_priority;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [STATUS_W-1:0] rsp_status;

   // when set, neither side idles (long calm stretch in the random part)
   bit quiet = 1'b0;

   ready_queue_scoreboard queue_model = new();

   priority_fifo_ready_queue i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_thread_id     (req_thread_id),
      .req_priority_req  (req_priority_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_thread   (rsp_head_thread),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver back-pressure, about 8 stalled cycles in a hundred
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 8);
   end

   // response monitor: sample at the rising edge
   always @(posedge clock) begin
      head_report_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.head_valid    = rsp_head_valid;
         seen.head_thread   = rsp_head_thread;
         seen.head_priority = rsp_head_priority;
         seen.entry_count   = rsp_entry_count;
         seen.status        = rsp_status;
         queue_model.check_response(seen);
      end
   end

   // one request: optional sender gap, then hold until accepted
   task automatic send_request(input logic op, input logic [THREAD_W-1:0] tid,
                               input logic [PRIO_W-1:0] prio);
      if (!quiet && $urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_thread_id    <= tid;
      req_priority_req <= prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_model.note_request(op, tid, prio);
   endtask

   initial begin
      int                  waited;
      int                  enq_pct;
      logic                op;
      logic [THREAD_W-1:0] tid;
      logic [PRIO_W-1:0]   prio;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      // remove from an empty queue, priority bits all ones to show they are ignored
      send_request(pfrq_pkg::OP_REMOVE, 4'd5, 8'hff);
      send_request(pfrq_pkg::OP_ENQUEUE, 4'd0, 8'hff);
      send_request(pfrq_pkg::OP_ENQUEUE, 4'd15, 8'h00);   // new head, most urgent
      send_request(pfrq_pkg::OP_ENQUEUE, 4'd3, 8'h00);    // equal priority goes behind thread 15
      send_request(pfrq_pkg::OP_ENQUEUE, 4'd15, 8'h07);   // already queued
      send_request(pfrq_pkg::OP_REMOVE, 4'd0, 8'h00);     // remove the tail
      // fill to capacity with repeated priorities for tie ordering
      for (int t = 0; t < DEPTH; t++)
         if (t != 3 && t != 15)
            send_request(pfrq_pkg::OP_ENQUEUE, THREAD_W'(t),
                         (t == 0) ? 8'hff : {t[1:0], 6'd0});
      // with all sixteen ids queued a further enqueue is always a duplicate,
      // so the queue-full status cannot occur at this depth
      send_request(pfrq_pkg::OP_ENQUEUE, 4'd7, 8'h10);
      send_request(pfrq_pkg::OP_REMOVE, 4'd9, 8'h55);     // middle
      send_request(pfrq_pkg::OP_REMOVE, 4'd15, 8'haa);    // head
      send_request(pfrq_pkg::OP_REMOVE, 4'd9, 8'h00);     // now absent

      // random part: alternating fill and drain phases so the queue swings
      // between empty and full, mostly legal requests with some duplicates
      // and removes of absent threads
      for (int n = 0; n < 1400; n++) begin
         quiet   = (n >= 500 && n < 800);
         enq_pct = ((n / 60) % 2 == 0) ? 80 : 30;
         // half the priorities from a tiny set to force ties
         prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 255))
                                     : PRIO_W'($urandom_range(0, 3));
         tid  = THREAD_W'($urandom_range(0, 15));
         if ($urandom_range(0, 99) < enq_pct) begin
            op = pfrq_pkg::OP_ENQUEUE;
            // usually look for a thread not yet queued
            if ($urandom_range(0, 9) != 0)
               repeat (8)
                  if (queue_model.find_slot(tid) < queue_model.used)
                     tid = THREAD_W'($urandom_range(0, 15));
         end else begin
            op = pfrq_pkg::OP_REMOVE;
            if (queue_model.used != 0 && $urandom_range(0, 4) != 0)
               tid = queue_model.slot_tid[$urandom_range(0, queue_model.used - 1)];
         end
         send_request(op, tid, prio);
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      // drain outstanding responses, then wait for anything stray
      waited = 0;
      while (queue_model.due_reports.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);

      if (queue_model.errors == 0 && queue_model.due_reports.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/pfrq_pkg.sv
design/pfrq_ctrl.sv
design/pfrq_datapath.sv
design/priority_fifo_ready_queue.sv
tb/priority_fifo_ready_queue_tb.sv
